@@ rtl/conv3x3_kernel_filter_assert.svh @@
// Assertion macros shared by the filter modules.
`ifndef CONV3X3_KERNEL_FILTER_ASSERT_SVH
`define CONV3X3_KERNEL_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define A_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define A_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define A_IMPL(label, clk, rst_n, prop)
`define A_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/c3kf_pkg.sv @@
// Package with shared types and constants of the 3x3 filter.
package c3kf_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int CW = $clog2(MaxWidth);
    localparam int RW = $clog2(MaxHeight);

    localparam logic [2:0] REG_TOP = 3'd0;
    localparam logic [2:0] REG_MID = 3'd1;
    localparam logic [2:0] REG_BOT = 3'd2;
    localparam logic [2:0] REG_DIV = 3'd3;
    localparam logic [2:0] REG_WID = 3'd4;
    localparam logic [2:0] REG_HGT = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MAC  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture pixel and read line stores
        logic shift;    // shift window, write line stores
        logic mac;      // accumulate one tap
        logic div_init; // start division
        logic div_step; // one quotient bit
        logic out_load; // move result to output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic interior;
        logic mac_last;
        logic div_last;
    } t_sts;
endpackage

@@ rtl/c3kf_datapath.sv @@
// Datapath: line stores, window, multiply-accumulate and serial divider.
`include "conv3x3_kernel_filter_assert.svh"
module c3kf_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c3kf_pkg::t_cmd       i_cmd,
    output c3kf_pkg::t_sts       o_sts,
    input  logic [7:0]           i_pixel_in,
    input  logic [23:0]          i_k_top,
    input  logic [23:0]          i_k_mid,
    input  logic [23:0]          i_k_bot,
    input  logic [7:0]           i_divisor,
    input  logic [10:0]          i_width,
    input  logic [10:0]          i_height,
    output logic [7:0]           o_pixel_out,
    output logic [9:0]           o_out_col,
    output logic [9:0]           o_out_row,
    output logic                 o_frame_done
);
    import c3kf_pkg::*;

    logic [7:0] mem_up [MaxWidth];
    logic [7:0] mem_lo [MaxWidth];
    logic [7:0] r_rd_up, r_rd_lo, r_px;
    logic [7:0] r_win [9];
    logic [CW-1:0] r_col, r_c;
    logic [RW-1:0] r_row, r_r;
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;
    logic [CW-1:0] c_cl;
    logic [RW-1:0] r_cl;
    logic [3:0] r_tap;
    logic signed [19:0] r_acc;
    logic [19:0] r_mag;
    logic r_neg;
    logic [19:0] r_quo;
    logic [8:0] r_rem;
    logic [4:0] r_bit;
    logic [7:0] r_dv;
    logic r_last;

    always_comb begin
        if (i_width < 11'd3) w_eff = (CW+1)'(3);
        else if (i_width > 11'(MaxWidth)) w_eff = (CW+1)'(MaxWidth);
        else w_eff = (CW+1)'(i_width);
        if (i_height < 11'd3) h_eff = (RW+1)'(3);
        else if (i_height > 11'(MaxHeight)) h_eff = (RW+1)'(MaxHeight);
        else h_eff = (RW+1)'(i_height);
        c_cl = ({1'b0, r_col} >= w_eff) ? CW'(w_eff - 1'b1) : r_col;
        r_cl = ({1'b0, r_row} >= h_eff) ? RW'(h_eff - 1'b1) : r_row;
    end

    logic [23:0] krow;
    logic [7:0]  kbyte, wpx;
    logic signed [17:0] prod;
    always_comb begin
        case (r_tap)
            4'd0, 4'd1, 4'd2: krow = i_k_top;
            4'd3, 4'd4, 4'd5: krow = i_k_mid;
            default:          krow = i_k_bot;
        endcase
        case (r_tap)
            4'd0, 4'd3, 4'd6: kbyte = krow[7:0];
            4'd1, 4'd4, 4'd7: kbyte = krow[15:8];
            default:          kbyte = krow[23:16];
        endcase
        wpx  = r_win[r_tap];
        prod = $signed({1'b0, wpx}) * $signed(kbyte);
    end

    // The magnitude shifts left one bit per step, so its top bit is the next dividend bit.
    logic [8:0] trial;
    assign trial = {r_rem[7:0], r_mag[19]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_up <= mem_up[c_cl];
            r_rd_lo <= mem_lo[c_cl];
            r_px    <= i_pixel_in;
            r_c     <= c_cl;
            r_r     <= r_cl;
        end
        if (i_cmd.shift) begin
            mem_up[r_c] <= r_rd_lo;
            mem_lo[r_c] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
            r_tap <= '0;
            r_bit <= '0;
        end else begin
            if (i_cmd.shift) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= r_rd_up;
                r_win[5] <= r_rd_lo;
                r_win[8] <= r_px;
                if ({1'b0, r_c} + 1'b1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= ({1'b0, r_r} + 1'b1 >= h_eff) ? '0 : r_r + 1'b1;
                end else begin
                    r_col <= r_c + 1'b1;
                    r_row <= r_r;
                end
                r_last <= ({1'b0, r_r} == h_eff - 1'b1) && ({1'b0, r_c} == w_eff - 1'b1);
                r_tap <= '0;
                r_acc <= '0;
            end
            if (i_cmd.mac) begin
                r_acc <= r_acc + 20'(prod);
                r_tap <= r_tap + 1'b1;
            end
            if (i_cmd.div_init) begin
                r_neg <= r_acc[19];
                r_mag <= r_acc[19] ? 20'(-r_acc) : 20'(r_acc);
                r_dv  <= (i_divisor == 8'd0) ? 8'd1 : i_divisor;
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= '0;
            end
            if (i_cmd.div_step) begin
                if (trial >= {1'b0, r_dv}) begin
                    r_rem <= trial - {1'b0, r_dv};
                    r_quo <= {r_quo[18:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[18:0], 1'b0};
                end
                r_mag <= {r_mag[18:0], 1'b0};
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_neg || r_quo == '0) o_pixel_out <= '0;
            else if (r_quo > 20'd255) o_pixel_out <= 8'd255;
            else o_pixel_out <= r_quo[7:0];
            o_out_col    <= r_c - 1'b1;
            o_out_row    <= r_r - 1'b1;
            o_frame_done <= r_last;
        end
    end

    assign o_sts.interior = (r_c >= CW'(2)) && (r_r >= RW'(2));
    assign o_sts.mac_last = (r_tap == 4'd9);
    assign o_sts.div_last = (r_bit == 5'd20);

    `A_NEVER(a_tap_range, i_clk, i_rst_n, r_tap > 4'd9)
    `A_NEVER(a_bit_range, i_clk, i_rst_n, r_bit > 5'd20)
    `A_IMPL(a_col_wrap, i_clk, i_rst_n, i_cmd.shift |=> ({1'b0, r_col} < w_eff))
endmodule

@@ rtl/c3kf_ctrl.sv @@
// Controller state machine sequencing each pixel through the datapath.
`include "conv3x3_kernel_filter_assert.svh"
module c3kf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  c3kf_pkg::t_sts i_sts,
    output c3kf_pkg::t_cmd o_cmd
);
    import c3kf_pkg::*;

    t_state r_state, n_state;
    logic r_ov, n_ov;
    logic out_free;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ov;

    always_comb begin
        n_state = r_state;
        n_ov = r_ov && !i_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.shift = 1'b1;
                n_state = i_sts.interior ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (i_sts.mac_last) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.mac = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_last && out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end else if (!i_sts.div_last) begin
                    o_cmd.div_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
    end

    `A_IMPL(a_onehot, i_clk, i_rst_n, $onehot(r_state))
    `A_NEVER(a_overwrite, i_clk, i_rst_n, o_cmd.out_load && r_ov && !i_ready)
    `A_IMPL(a_load_next, i_clk, i_rst_n, o_cmd.load |=> (r_state == S_READ))
endmodule

@@ rtl/conv3x3_kernel_filter.sv @@
// Each interior input item passes through load, window shift, multiply-accumulate of
// the nine taps, divider setup, 20 divider steps and output load to give its result.
// A new item is accepted only once the last one is through, and the result may wait
// for the receiver; border items give no result.
// Reset is synchronous, active low; it restores default registers,
// clears window and counters; line stores are not cleared.
module conv3x3_kernel_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pixel_out,
    output logic [9:0]  o_out_col,
    output logic [9:0]  o_out_row,
    output logic        o_frame_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import c3kf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [23:0] r_k_top, r_k_mid, r_k_bot;
    logic [7:0]  r_div;
    logic [10:0] r_wid, r_hgt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top <= 24'h010101;
            r_k_mid <= 24'h010101;
            r_k_bot <= 24'h010101;
            r_div   <= 8'd9;
            r_wid   <= 11'd256;
            r_hgt   <= 11'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TOP: r_k_top <= i_cfg_data;
                REG_MID: r_k_mid <= i_cfg_data;
                REG_BOT: r_k_bot <= i_cfg_data;
                REG_DIV: r_div   <= i_cfg_data[7:0];
                REG_WID: r_wid   <= i_cfg_data[10:0];
                REG_HGT: r_hgt   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    c3kf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    c3kf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_pixel_in(i_pixel_in),
        .i_k_top(r_k_top), .i_k_mid(r_k_mid), .i_k_bot(r_k_bot),
        .i_divisor(r_div), .i_width(r_wid), .i_height(r_hgt),
        .o_pixel_out(o_pixel_out), .o_out_col(o_out_col),
        .o_out_row(o_out_row), .o_frame_done(o_frame_done)
    );
endmodule
